FILE: rtl/stc_pkg.sv
package stc_pkg;

	// Number format and word sizes
	localparam int FRAC_BITS  = 16;
	localparam int WORD_BITS  = 32;
	localparam int FIELD_BITS = 32;
	localparam int SAT_BITS   = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
	localparam int PROD_BITS  = 2 * FIELD_BITS;

	// Divider sizes: magnitude numerator, magnitude divisor, quotient bits
	localparam int NUM_BITS = 64;
	localparam int DEN_BITS = FIELD_BITS;
	localparam int DQ_BITS  = FIELD_BITS + FRAC_BITS;
	localparam int DIV_LAT  = DQ_BITS + 1;
	localparam int OVF_BITS = DQ_BITS + DEN_BITS;

	// Signed accumulator for the numerators before clamping
	localparam int ACC_BITS = NUM_BITS + 2;

	// Dividers in each bank
	localparam int NUM_DIV = 5;

	typedef logic signed [FIELD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	typedef struct packed {
		logic [NUM_BITS-1:0] num;
		logic [DEN_BITS-1:0] den;
		logic                rneg;
	} div_req_t;

	typedef struct packed {
		logic [DQ_BITS-1:0] quo;
		logic               ovf;
		logic               rneg;
	} div_res_t;

	typedef struct packed {
		logic                neg;
		logic [NUM_BITS-1:0] mag;
	} smag_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} sat_t;

	// Values that travel beside the first divider bank
	typedef struct packed {
		logic                dry;
		logic [DEN_BITS-1:0] hmag;
		logic                hneg;
		word_t               hx;
		word_t               hy;
		word_t               bxx;
		word_t               byy;
		word_t               bxy;
		prod_t               zhxx;
		prod_t               zhyy;
		prod_t               zhxy;
	} side_a_t;

	// Values that travel beside the second divider bank
	typedef struct packed {
		logic  dry;
		word_t c0;
		word_t c1;
		word_t c2;
		logic  sat;
	} side_b_t;

endpackage

FILE: rtl/sigma_transform_coefficients.sv
// Path from the input transfer to out_valid: three input stages, a 49-stage
// divider bank, three middle stages, a second 49-stage bank, output.
// Throughput: one item per cycle unless the output stalls; the chained dividers set the latency.
// A stall at the output holds the whole pipeline in place.
// Reset (arst_n low, asynchronous) clears every valid bit; data is not reset.
module sigma_transform_coefficients import stc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  word_t depth,
	input  word_t depth_dx,
	input  word_t depth_dy,
	input  word_t depth_dxx,
	input  word_t depth_dyy,
	input  word_t depth_dxy,
	input  word_t level_dx,
	input  word_t level_dy,
	input  word_t level_dxx,
	input  word_t level_dyy,
	input  word_t level_dxy,
	input  word_t mesh_z,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t coef_ax,
	output word_t coef_ay,
	output word_t coef_az,
	output word_t coef_bx,
	output word_t coef_by,
	output word_t coef_cxy,
	output word_t coef_cxz,
	output word_t coef_cyz,
	output logic  dry_point,
	output logic  saturated
);

	localparam int V_BITS = DQ_BITS + 2;
	localparam logic signed [V_BITS-1:0] SMAX =
		V_BITS'((65'sd1 <<< (SAT_BITS - 1)) - 65'sd1);
	localparam logic signed [V_BITS-1:0] SMIN = -SMAX - V_BITS'(1);
	localparam logic [DQ_BITS-1:0] TLIM = DQ_BITS'((65'd1 << (63 - FRAC_BITS)) - 65'd1);
	localparam logic signed [ACC_BITS-1:0] NLIM =
		ACC_BITS'((66'sd1 <<< (NUM_BITS - 1)) - 66'sd1);

	// Clamp a numerator to +-(2^63-1) and split sign and magnitude
	function automatic smag_t clamp_mag(input logic signed [ACC_BITS-1:0] n);
		smag_t r;
		logic signed [ACC_BITS-1:0] a;
		a = (n < 0) ? -n : n;
		r.neg = n < 0;
		if (n > NLIM || n < -NLIM)
			r.mag = NLIM[NUM_BITS-1:0];
		else
			r.mag = a[NUM_BITS-1:0];
		return r;
	endfunction

	// Apply the sign of the result and clip to the coefficient range
	function automatic sat_t sat_quo(input div_res_t d);
		sat_t r;
		logic signed [V_BITS-1:0] v;
		v = d.rneg ? -$signed({2'b00, d.quo}) : $signed({2'b00, d.quo});
		if (d.ovf) begin
			r.sat = 1'b1;
			r.val = d.rneg ? SMIN[FIELD_BITS-1:0] : SMAX[FIELD_BITS-1:0];
		end else if (v > SMAX) begin
			r.sat = 1'b1;
			r.val = SMAX[FIELD_BITS-1:0];
		end else if (v < SMIN) begin
			r.sat = 1'b1;
			r.val = SMIN[FIELD_BITS-1:0];
		end else begin
			r.sat = 1'b0;
			r.val = v[FIELD_BITS-1:0];
		end
		return r;
	endfunction

	logic en;

	// Stage 1: input register
	logic  v_s1;
	word_t h_s1, hx_s1, hy_s1, hxx_s1, hyy_s1, hxy_s1;
	word_t bx_s1, by_s1, bxx_s1, byy_s1, bxy_s1, z_s1;

	// Stage 2: z products, depth magnitude
	logic                v_s2, dry_s2, hneg_s2;
	logic [DEN_BITS-1:0] hmag_s2;
	word_t               hx_s2, hy_s2, bx_s2, by_s2, bxx_s2, byy_s2, bxy_s2;
	prod_t               zhx_s2, zhy_s2, zhxx_s2, zhyy_s2, zhxy_s2;

	// Stage 3: first bank requests
	logic     v_s3;
	side_a_t  sa_s3;
	div_req_t req_a_s3 [NUM_DIV];

	// First bank
	div_res_t res_a [NUM_DIV];
	logic     va_q  [DIV_LAT];
	side_a_t  sa_q  [DIV_LAT];

	// Stage 4: saturated ax, ay, az and the first quotients for cxz, cyz
	logic               v_s4, sat_s4;
	side_a_t            sa_s4;
	word_t              c0_s4, c1_s4, c2_s4;
	logic [DQ_BITS-1:0] t6_s4, t7_s4;
	logic               t6neg_s4, t7neg_s4;

	// Stage 5: products with ax, ay
	logic               v_s5, sat_s5;
	side_a_t            sa_s5;
	word_t              c0_s5, c1_s5, c2_s5;
	logic [DQ_BITS-1:0] t6_s5, t7_s5;
	logic               t6neg_s5, t7neg_s5;
	prod_t              p0x_s5, p1y_s5, p0y_s5, p1x_s5;

	// Stage 6: second bank requests
	logic     v_s6;
	side_b_t  sb_s6;
	div_req_t req_b_s6 [NUM_DIV];

	// Second bank
	div_res_t res_b [NUM_DIV];
	logic     vb_q  [DIV_LAT];
	side_b_t  sb_q  [DIV_LAT];

	// Pipeline advances unless a result waits at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				va_q[i] <= 1'b0;
				vb_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			va_q[0]   <= v_s3;
			v_s4      <= va_q[DIV_LAT-1];
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			vb_q[0]   <= v_s6;
			out_valid <= vb_q[DIV_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				va_q[i] <= va_q[i-1];
				vb_q[i] <= vb_q[i-1];
			end
		end
	end

	// Stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			h_s1   <= depth;
			hx_s1  <= depth_dx;
			hy_s1  <= depth_dy;
			hxx_s1 <= depth_dxx;
			hyy_s1 <= depth_dyy;
			hxy_s1 <= depth_dxy;
			bx_s1  <= level_dx;
			by_s1  <= level_dy;
			bxx_s1 <= level_dxx;
			byy_s1 <= level_dyy;
			bxy_s1 <= level_dxy;
			z_s1   <= mesh_z;
		end
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (en) begin
			dry_s2  <= h_s1 == '0;
			hneg_s2 <= h_s1 < 0;
			hmag_s2 <= (h_s1 < 0) ? DEN_BITS'(-(FIELD_BITS+1)'(h_s1))
				: DEN_BITS'(h_s1);
			hx_s2   <= hx_s1;
			hy_s2   <= hy_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
			bxx_s2  <= bxx_s1;
			byy_s2  <= byy_s1;
			bxy_s2  <= bxy_s1;
			zhx_s2  <= z_s1 * hx_s1;
			zhy_s2  <= z_s1 * hy_s1;
			zhxx_s2 <= z_s1 * hxx_s1;
			zhyy_s2 <= z_s1 * hyy_s1;
			zhxy_s2 <= z_s1 * hxy_s1;
		end
	end

	// Stage 3: numerators for ax, ay, az and hx/h, hy/h
	always_ff @(posedge clk) begin
		smag_t m0, m1, m6, m7;
		m0 = clamp_mag((ACC_BITS'(bx_s2) <<< FRAC_BITS) + ACC_BITS'(zhx_s2));
		m1 = clamp_mag((ACC_BITS'(by_s2) <<< FRAC_BITS) + ACC_BITS'(zhy_s2));
		m6 = clamp_mag(ACC_BITS'(hx_s2) <<< FRAC_BITS);
		m7 = clamp_mag(ACC_BITS'(hy_s2) <<< FRAC_BITS);
		if (en) begin
			req_a_s3[0] <= '{num: m0.mag, den: hmag_s2, rneg: !(m0.neg ^ hneg_s2)};
			req_a_s3[1] <= '{num: m1.mag, den: hmag_s2, rneg: !(m1.neg ^ hneg_s2)};
			req_a_s3[2] <= '{num: NUM_BITS'(1) << (2 * FRAC_BITS), den: hmag_s2,
				rneg: hneg_s2};
			req_a_s3[3] <= '{num: m6.mag, den: hmag_s2, rneg: m6.neg ^ hneg_s2};
			req_a_s3[4] <= '{num: m7.mag, den: hmag_s2, rneg: m7.neg ^ hneg_s2};
			sa_s3 <= '{dry: dry_s2, hmag: hmag_s2, hneg: hneg_s2, hx: hx_s2, hy: hy_s2,
				bxx: bxx_s2, byy: byy_s2, bxy: bxy_s2,
				zhxx: zhxx_s2, zhyy: zhyy_s2, zhxy: zhxy_s2};
		end
	end

	// First divider bank and its side line
	for (genvar g = 0; g < NUM_DIV; g++) begin : g_bank_a
		stc_div u_div (
			.clk (clk),
			.en  (en),
			.req (req_a_s3[g]),
			.res (res_a[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_q[0] <= sa_s3;
			for (int i = 1; i < DIV_LAT; i++)
				sa_q[i] <= sa_q[i-1];
		end
	end

	// Stage 4: clip ax, ay, az; limit the intermediate quotients
	always_ff @(posedge clk) begin
		sat_t r0, r1, r2;
		r0 = sat_quo(res_a[0]);
		r1 = sat_quo(res_a[1]);
		r2 = sat_quo(res_a[2]);
		if (en) begin
			sa_s4    <= sa_q[DIV_LAT-1];
			c0_s4    <= r0.val;
			c1_s4    <= r1.val;
			c2_s4    <= r2.val;
			sat_s4   <= r0.sat | r1.sat | r2.sat;
			t6_s4    <= (res_a[3].quo > TLIM) ? TLIM : res_a[3].quo;
			t7_s4    <= (res_a[4].quo > TLIM) ? TLIM : res_a[4].quo;
			t6neg_s4 <= res_a[3].rneg;
			t7neg_s4 <= res_a[4].rneg;
		end
	end

	// Stage 5
	always_ff @(posedge clk) begin
		if (en) begin
			sa_s5    <= sa_s4;
			c0_s5    <= c0_s4;
			c1_s5    <= c1_s4;
			c2_s5    <= c2_s4;
			sat_s5   <= sat_s4;
			t6_s5    <= t6_s4;
			t7_s5    <= t7_s4;
			t6neg_s5 <= t6neg_s4;
			t7neg_s5 <= t7neg_s4;
			p0x_s5   <= c0_s4 * sa_s4.hx;
			p1y_s5   <= c1_s4 * sa_s4.hy;
			p0y_s5   <= c0_s4 * sa_s4.hy;
			p1x_s5   <= c1_s4 * sa_s4.hx;
		end
	end

	// Stage 6: numerators for bx, by, cxy, cxz, cyz
	always_ff @(posedge clk) begin
		smag_t m3, m4, m5;
		m3 = clamp_mag((ACC_BITS'(sa_s5.bxx) <<< FRAC_BITS) + ACC_BITS'(sa_s5.zhxx)
			+ (ACC_BITS'(p0x_s5) <<< 1));
		m4 = clamp_mag((ACC_BITS'(sa_s5.byy) <<< FRAC_BITS) + ACC_BITS'(sa_s5.zhyy)
			+ (ACC_BITS'(p1y_s5) <<< 1));
		m5 = clamp_mag((ACC_BITS'(sa_s5.bxy) <<< FRAC_BITS) + ACC_BITS'(p0y_s5)
			+ ACC_BITS'(p1x_s5) + ACC_BITS'(sa_s5.zhxy));
		if (en) begin
			req_b_s6[0] <= '{num: m3.mag, den: sa_s5.hmag, rneg: !(m3.neg ^ sa_s5.hneg)};
			req_b_s6[1] <= '{num: m4.mag, den: sa_s5.hmag, rneg: !(m4.neg ^ sa_s5.hneg)};
			req_b_s6[2] <= '{num: m5.mag, den: sa_s5.hmag, rneg: !(m5.neg ^ sa_s5.hneg)};
			req_b_s6[3] <= '{num: NUM_BITS'(t6_s5) << FRAC_BITS, den: sa_s5.hmag,
				rneg: !(t6neg_s5 ^ sa_s5.hneg)};
			req_b_s6[4] <= '{num: NUM_BITS'(t7_s5) << FRAC_BITS, den: sa_s5.hmag,
				rneg: !(t7neg_s5 ^ sa_s5.hneg)};
			sb_s6 <= '{dry: sa_s5.dry, c0: c0_s5, c1: c1_s5, c2: c2_s5, sat: sat_s5};
		end
	end

	// Second divider bank and its side line
	for (genvar g = 0; g < NUM_DIV; g++) begin : g_bank_b
		stc_div u_div (
			.clk (clk),
			.en  (en),
			.req (req_b_s6[g]),
			.res (res_b[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q[0] <= sb_s6;
			for (int i = 1; i < DIV_LAT; i++)
				sb_q[i] <= sb_q[i-1];
		end
	end

	// Output register; a dry point forces every coefficient to zero
	always_ff @(posedge clk) begin
		sat_t    r3, r4, r5, r6, r7;
		side_b_t sb;
		r3 = sat_quo(res_b[0]);
		r4 = sat_quo(res_b[1]);
		r5 = sat_quo(res_b[2]);
		r6 = sat_quo(res_b[3]);
		r7 = sat_quo(res_b[4]);
		sb = sb_q[DIV_LAT-1];
		if (en) begin
			dry_point <= sb.dry;
			if (sb.dry) begin
				coef_ax   <= '0;
				coef_ay   <= '0;
				coef_az   <= '0;
				coef_bx   <= '0;
				coef_by   <= '0;
				coef_cxy  <= '0;
				coef_cxz  <= '0;
				coef_cyz  <= '0;
				saturated <= 1'b0;
			end else begin
				coef_ax   <= sb.c0;
				coef_ay   <= sb.c1;
				coef_az   <= sb.c2;
				coef_bx   <= r3.val;
				coef_by   <= r4.val;
				coef_cxy  <= r5.val;
				coef_cxz  <= r6.val;
				coef_cyz  <= r7.val;
				saturated <= sb.sat | r3.sat | r4.sat | r5.sat | r6.sat | r7.sat;
			end
		end
	end

`ifndef SYNTHESIS
	// A dry point carries no coefficient and no clip
	a_dry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dry_point |-> coef_az == '0 && coef_ax == '0 && coef_cxz == '0
			&& !saturated)
		else $error("dry point with nonzero result");

	// A held stage keeps its item while the output stalls
	a_hold_mid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !en |=> v_s6)
		else $error("item lost in a stalled stage");

	// A positive depth never gives a negative reciprocal at stage 4
	a_az_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !sa_s4.hneg && !sa_s4.dry |-> !c2_s4[FIELD_BITS-1])
		else $error("reciprocal has wrong sign");
`endif

endmodule

FILE: rtl/stc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotients at or above 2^DQ_BITS are flagged as overflow.
module stc_div import stc_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  div_req_t req,
	output div_res_t res
);

	logic [NUM_BITS-1:0] rem_s  [DQ_BITS];
	logic [DEN_BITS-1:0] den_s  [DQ_BITS];
	logic [DQ_BITS-1:0]  quo_s  [DQ_BITS+1];
	logic                rneg_s [DQ_BITS+1];
	logic                ovf_s  [DQ_BITS+1];

	// Entry stage: range check against the full quotient width
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= req.num;
			den_s[0]  <= req.den;
			quo_s[0]  <= '0;
			rneg_s[0] <= req.rneg;
			ovf_s[0]  <= {(OVF_BITS-NUM_BITS)'(0), req.num} >= {req.den, DQ_BITS'(0)};
		end
	end

	// One bit per stage, most significant first
	for (genvar k = 1; k <= DQ_BITS; k++) begin : g_step
		localparam int BIT = DQ_BITS - k;
		logic [NUM_BITS-1:0] part;
		logic                hit;

		assign part = rem_s[k-1] >> BIT;
		assign hit  = part >= NUM_BITS'(den_s[k-1]);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= quo_s[k-1] | (hit ? (DQ_BITS'(1) << BIT) : DQ_BITS'(0));
				rneg_s[k] <= rneg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
			end
		end

		if (k < DQ_BITS) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= hit ? rem_s[k-1] - (NUM_BITS'(den_s[k-1]) << BIT)
						: rem_s[k-1];
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign res = '{quo: quo_s[DQ_BITS], ovf: ovf_s[DQ_BITS], rneg: rneg_s[DQ_BITS]};

endmodule
